// File: hw/rtl/textured_span_pixel_writer_defines.svh
// assertion helpers used by the rtl
`ifndef TEXTURED_SPAN_PIXEL_WRITER_DEFINES_SVH
`define TEXTURED_SPAN_PIXEL_WRITER_DEFINES_SVH

// same-cycle implication
`define TSPW_ASSERT_IMP(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSPW_ASSERT_NXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tspw_pkg.sv
`timescale 1ns / 1ps
package tspw_pkg;

	localparam int PIX_ADDR_W = 19;
	localparam int PAGE_SHIFT = 18;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = 5;

	typedef enum logic [1:0] {
		MODE_TEX_WRITE  = 2'd0,
		MODE_SPAN_START = 2'd1,
		MODE_PIXEL      = 2'd2
	} item_mode_t;

	typedef enum logic [1:0] {
		RM_FLAT      = 2'd0,
		RM_TEX       = 2'd1,
		RM_TEX_TRANS = 2'd2,
		RM_MASKED    = 2'd3
	} render_mode_t;

	localparam logic [REG_IDX_W-1:0] REG_RENDER_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLOUR_WORD  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DITHER_ON    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TEXTURE_PAGE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEST_PAGE    = 3'd4;

	typedef struct packed {
		render_mode_t render_mode;
		logic [15:0]  colour_word;
		logic         dither_on;
		logic [9:0]   texture_page;
		logic         dest_page;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [16:0]        tex_word_addr;
		logic [15:0]        tex_word;
		logic [8:0]         line_y;
		logic [8:0]         first_x;
		logic [9:0]         end_x;
		logic signed [31:0] u_start;
		logic signed [31:0] v_start;
		logic signed [31:0] u_step;
		logic signed [31:0] v_step;
	} item_t;

	typedef struct packed {
		logic [PIX_ADDR_W-1:0] addr;
		logic                  last;
		logic                  byte_sel;
		render_mode_t          render_mode;
		logic [15:0]           colour_word;
	} pix_req_t;

endpackage

// File: hw/rtl/tspw_if.sv
`timescale 1ns / 1ps
interface tspw_in_if;
	import tspw_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [16:0]        tex_word_addr;
	logic [15:0]        tex_word;
	logic [8:0]         line_y;
	logic [8:0]         first_x;
	logic [9:0]         end_x;
	logic signed [31:0] u_start;
	logic signed [31:0] v_start;
	logic signed [31:0] u_step;
	logic signed [31:0] v_step;

	modport source (
		output valid, mode, tex_word_addr, tex_word, line_y, first_x, end_x,
		output u_start, v_start, u_step, v_step,
		input  ready
	);
	modport sink (
		input  valid, mode, tex_word_addr, tex_word, line_y, first_x, end_x,
		input  u_start, v_start, u_step, v_step,
		output ready
	);
endinterface

interface tspw_out_if;
	import tspw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_ADDR_W-1:0] pixel_addr;
	logic [15:0]           pixel_value;
	logic                  write_enable;
	logic                  span_last;

	modport source (
		output valid, pixel_addr, pixel_value, write_enable, span_last,
		input  ready
	);
	modport sink (
		input  valid, pixel_addr, pixel_value, write_enable, span_last,
		output ready
	);
endinterface

// File: hw/rtl/textured_span_pixel_writer.sv
// Span pixel writer: takes one item per clock (texture word write, span start or
// pixel step) and gives one frame buffer write, masked by write_enable, for every
// pixel step of an active span. A pixel step reads the texel from a synchronous
// word-wide texture memory in the cycle it is accepted and the pixel passes the read
// stage and leaves from the output register; one memory read port and one write port
// set the rate of one item a clock. The input stalls only while a pixel waits in
// the read stage and the output register is held by the sink. Texture memory holds
// 2**TEX_ADDR_BITS bytes and is not cleared at reset; config registers sit at byte addresses 4*i.
`timescale 1ns / 1ps
`include "textured_span_pixel_writer_defines.svh"
module textured_span_pixel_writer #(
	parameter int TEX_ADDR_BITS = 18,
	parameter int LINE_PITCH    = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tspw_in_if.sink                      in_item,
	tspw_out_if.source                   out_pix,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tspw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tspw_pkg::*;

	localparam int WordBits = TEX_ADDR_BITS - 1;

	cfg_t                  cfg;
	item_t                 item;
	pix_req_t              pix;
	pix_req_t              pix_s1;
	logic                  s1_v_q;
	logic                  out_v_q;
	logic                  out_free;
	logic                  in_ready;
	logic                  fire;
	logic                  span_active;
	logic                  rd_en;
	logic [WordBits-1:0]   rd_idx;
	logic [15:0]           rd_data;
	logic [7:0]            texel;
	logic [15:0]           value;
	logic                  we;
	logic [PIX_ADDR_W-1:0] pixel_addr_q;
	logic [15:0]           pixel_value_q;
	logic                  write_enable_q;
	logic                  span_last_q;

	assign item.mode          = in_item.mode;
	assign item.tex_word_addr = in_item.tex_word_addr;
	assign item.tex_word      = in_item.tex_word;
	assign item.line_y        = in_item.line_y;
	assign item.first_x       = in_item.first_x;
	assign item.end_x         = in_item.end_x;
	assign item.u_start       = in_item.u_start;
	assign item.v_start       = in_item.v_start;
	assign item.u_step        = in_item.u_step;
	assign item.v_step        = in_item.v_step;

	assign out_free      = !out_v_q || out_pix.ready;
	assign in_ready      = !s1_v_q || out_free;
	assign in_item.ready = in_ready;
	assign fire          = in_item.valid && in_ready;

	tspw_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tspw_span_gen #(
		.TEX_ADDR_BITS (TEX_ADDR_BITS),
		.LINE_PITCH    (LINE_PITCH)
	) u_span (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item),
		.cfg         (cfg),
		.span_active (span_active),
		.rd_en       (rd_en),
		.rd_idx      (rd_idx),
		.pix         (pix)
	);

	tspw_tex_mem #(
		.WORD_BITS (WordBits)
	) u_tex (
		.clk     (clk),
		.wr_en   (fire && (item.mode == MODE_TEX_WRITE)),
		.wr_idx  (WordBits'(item.tex_word_addr)),
		.wr_data (item.tex_word),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ready) begin
			s1_v_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pix_s1 <= pix;
		end
	end

	assign texel = pix_s1.byte_sel ? rd_data[15:8] : rd_data[7:0];

	always_comb begin
		case (pix_s1.render_mode)
			RM_FLAT: begin
				value = pix_s1.colour_word;
				we    = 1'b1;
			end
			RM_TEX: begin
				value = {pix_s1.colour_word[15:8], texel};
				we    = 1'b1;
			end
			RM_TEX_TRANS: begin
				value = {pix_s1.colour_word[15:8], texel};
				we    = texel != 8'd0;
			end
			default: begin
				value = pix_s1.colour_word;
				we    = texel != 8'd0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_v_q) begin
			pixel_addr_q   <= pix_s1.addr;
			pixel_value_q  <= value;
			write_enable_q <= we;
			span_last_q    <= pix_s1.last;
		end
	end

	assign out_pix.valid        = out_v_q;
	assign out_pix.pixel_addr   = pixel_addr_q;
	assign out_pix.pixel_value  = pixel_value_q;
	assign out_pix.write_enable = write_enable_q;
	assign out_pix.span_last    = span_last_q;

	`TSPW_ASSERT_IMP(a_stall_full, clk, arst_n, !in_ready, s1_v_q && out_v_q && !out_pix.ready, "input stalled with room in the pipe")
	`TSPW_ASSERT_NXT(a_pix_reads, clk, arst_n, fire && (item.mode == MODE_PIXEL) && span_active, s1_v_q, "pixel step lost before the read stage")
	`TSPW_ASSERT_IMP(a_last_ends, clk, arst_n, s1_v_q && pix_s1.last, !span_active, "span still active after its last pixel")
	`TSPW_ASSERT_IMP(a_out_source, clk, arst_n, $rose(out_v_q), $past(s1_v_q), "output item without a read stage item")

endmodule

// File: hw/rtl/tspw_apb_regs.sv
`timescale 1ns / 1ps
module tspw_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tspw_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output tspw_pkg::cfg_t                 cfg
);
	import tspw_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RENDER_MODE:  cfg_q.render_mode  <= render_mode_t'(pwdata[1:0]);
				REG_COLOUR_WORD:  cfg_q.colour_word  <= pwdata[15:0];
				REG_DITHER_ON:    cfg_q.dither_on    <= pwdata[0];
				REG_TEXTURE_PAGE: cfg_q.texture_page <= pwdata[9:0];
				REG_DEST_PAGE:    cfg_q.dest_page    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RENDER_MODE:  prdata = {30'd0, cfg_q.render_mode};
			REG_COLOUR_WORD:  prdata = {16'd0, cfg_q.colour_word};
			REG_DITHER_ON:    prdata = {31'd0, cfg_q.dither_on};
			REG_TEXTURE_PAGE: prdata = {22'd0, cfg_q.texture_page};
			REG_DEST_PAGE:    prdata = {31'd0, cfg_q.dest_page};
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/tspw_tex_mem.sv
`timescale 1ns / 1ps
module tspw_tex_mem #(
	parameter int WORD_BITS = 17
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [WORD_BITS-1:0] wr_idx,
	input  logic [15:0]          wr_data,
	input  logic                 rd_en,
	input  logic [WORD_BITS-1:0] rd_idx,
	output logic [15:0]          rd_data
);

	logic [15:0] mem [2**WORD_BITS];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/tspw_span_gen.sv
`timescale 1ns / 1ps
module tspw_span_gen #(
	parameter int TEX_ADDR_BITS = 18,
	parameter int LINE_PITCH    = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  tspw_pkg::item_t          item,
	input  tspw_pkg::cfg_t           cfg,
	output logic                     span_active,
	output logic                     rd_en,
	output logic [TEX_ADDR_BITS-2:0] rd_idx,
	output tspw_pkg::pix_req_t       pix
);
	import tspw_pkg::*;

	logic [9:0]  pos_x_q;
	logic [9:0]  stop_pos_q;
	logic [8:0]  span_line_q;
	logic [31:0] u_acc_q;
	logic [31:0] v_acc_q;
	logic [31:0] u_inc_q;
	logic [31:0] v_inc_q;
	logic        active_q;

	logic                     odd_start;
	logic [9:0]               x_start;
	logic [31:0]              u_first;
	logic [31:0]              v_first;
	logic [31:0]              u_inc_new;
	logic [31:0]              v_inc_new;
	logic [10:0]              x_next;
	logic                     last;
	logic [TEX_ADDR_BITS-1:0] tex_byte;
	logic                     is_start;
	logic                     is_pix;

	assign is_start = fire && (item.mode == MODE_SPAN_START);
	assign is_pix   = fire && (item.mode == MODE_PIXEL) && active_q;

	assign odd_start = cfg.dither_on & (item.line_y[0] ^ item.first_x[0]);
	assign x_start   = {1'b0, item.first_x} + {9'd0, odd_start};
	assign u_first   = item.u_start + (odd_start ? item.u_step : 32'd0);
	assign v_first   = item.v_start + (odd_start ? item.v_step : 32'd0);
	assign u_inc_new = cfg.dither_on ? {item.u_step[30:0], 1'b0} : item.u_step;
	assign v_inc_new = cfg.dither_on ? {item.v_step[30:0], 1'b0} : item.v_step;

	assign x_next = {1'b0, pos_x_q} + 11'd1 + {10'd0, cfg.dither_on};
	assign last   = x_next >= {1'b0, stop_pos_q};

	assign tex_byte = TEX_ADDR_BITS'({cfg.texture_page, 8'h00})
		+ TEX_ADDR_BITS'({v_acc_q[23:16], 8'h00})
		+ TEX_ADDR_BITS'($signed(u_acc_q[31:16]));

	assign rd_en  = is_pix;
	assign rd_idx = tex_byte[TEX_ADDR_BITS-1:1];

	assign pix.addr = {cfg.dest_page, {PAGE_SHIFT{1'b0}}}
		+ PIX_ADDR_W'(32'(span_line_q) * 32'(LINE_PITCH))
		+ PIX_ADDR_W'(pos_x_q);
	assign pix.last        = last;
	assign pix.byte_sel    = tex_byte[0];
	assign pix.render_mode = cfg.render_mode;
	assign pix.colour_word = cfg.colour_word;

	assign span_active = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			stop_pos_q  <= '0;
			span_line_q <= '0;
			u_acc_q     <= '0;
			v_acc_q     <= '0;
			u_inc_q     <= '0;
			v_inc_q     <= '0;
			active_q    <= 1'b0;
		end else if (is_start) begin
			pos_x_q     <= x_start;
			stop_pos_q  <= item.end_x;
			span_line_q <= item.line_y;
			u_acc_q     <= u_first;
			v_acc_q     <= v_first;
			u_inc_q     <= u_inc_new;
			v_inc_q     <= v_inc_new;
			active_q    <= x_start < item.end_x;
		end else if (is_pix) begin
			pos_x_q  <= x_next[9:0];
			u_acc_q  <= u_acc_q + u_inc_q;
			v_acc_q  <= v_acc_q + v_inc_q;
			active_q <= !last;
		end
	end

endmodule
